FILE: src/sfrr_pkg.sv
// Shared types, codes and constants of the framed SPI request/response sequencer.
package sfrr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  WAKE_BYTE    = 8'hFF;
    localparam logic [7:0]  CMD_WRITE    = 8'h01;
    localparam logic [7:0]  CMD_READ     = 8'h02;
    localparam logic [7:0]  FILL_BYTE    = 8'h00;
    localparam logic [15:0] SIZE_INVALID = 16'hFFFF;
    localparam logic [16:0] DISCARD_MAX  = 17'h1FFFF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_IRQ     = 2'd2,
        OP_REPLY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_LINK = 2'd0,
        KIND_HOST = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_LARGE = 2'd2
    } status_t;

    // Work handed from the front to the back; each expands to one or more beats.
    typedef enum logic [2:0] {
        JOB_DONE,
        JOB_LINK,
        JOB_START,
        JOB_IRQ,
        JOB_RESP
    } job_op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_length;
        logic [15:0] response_capacity;
        logic        buffer_present;
        logic [7:0]  payload_byte;
        logic [7:0]  link_reply;
    } sfrr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  link_byte;
        logic        hold_select;
        logic [7:0]  host_byte;
        logic [15:0] response_size;
        logic [1:0]  status;
        logic        last;
    } sfrr_out_t;

    typedef struct packed {
        job_op_t     op;
        logic [7:0]  data;
        logic        hold;
        logic        host;
        logic        final_beat;
        logic [15:0] size;
        status_t     status;
    } job_t;

endpackage

FILE: src/sfrr_stream_if.sv
// Valid/ready channels for request items and result beats.
interface sfrr_req_if;
    logic             valid;
    logic             ready;
    sfrr_pkg::sfrr_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sfrr_rsp_if;
    logic              valid;
    logic              ready;
    sfrr_pkg::sfrr_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/sfrr_front.sv
// Front end: accepts request items, tracks the transaction phase, queues jobs.
module sfrr_front (
    input  logic          clk,
    input  logic          rst_n,
    sfrr_req_if.sink      request,
    input  logic          q_full,
    output logic          push,
    output sfrr_pkg::job_t job
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_WAIT_IRQ,
        PH_SIZE_HI,
        PH_SIZE_LO,
        PH_RESP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] req_rem_reg, req_rem_next;
    logic [15:0] cap_reg, cap_next;
    logic [15:0] resp_rem_reg, resp_rem_next;
    logic [7:0]  size_hi_reg, size_hi_next;
    logic [16:0] discard_reg, discard_next;
    logic        deliver_reg, deliver_next;
    logic        cap_zero_reg, cap_zero_next;

    logic        accept;
    logic [2:0]  discard_add;
    logic [17:0] discard_sum;
    logic [15:0] size_word;
    logic [15:0] marker;
    logic [15:0] start_marker;
    logic [15:0] resp_left;
    sfrr_pkg::sfrr_in_t it;

    assign request.ready = !q_full;
    assign accept        = request.valid && request.ready;
    assign it            = request.payload;
    assign size_word     = {size_hi_reg, it.link_reply};
    assign marker        = cap_zero_reg ? sfrr_pkg::SIZE_INVALID : 16'h0000;
    assign start_marker  = (it.response_capacity == 16'h0000) ? sfrr_pkg::SIZE_INVALID
                                                               : 16'h0000;
    assign resp_left     = resp_rem_reg - 16'd1;
    assign discard_sum   = {1'b0, discard_reg} + {15'd0, discard_add};

    always_comb
    begin
        phase_next    = phase_reg;
        req_rem_next  = req_rem_reg;
        cap_next      = cap_reg;
        resp_rem_next = resp_rem_reg;
        size_hi_next  = size_hi_reg;
        deliver_next  = deliver_reg;
        cap_zero_next = cap_zero_reg;
        discard_add   = 3'd0;
        discard_next  = discard_reg;
        push          = 1'b0;
        job           = '0;
        job.op        = sfrr_pkg::JOB_LINK;
        job.status    = sfrr_pkg::STATUS_OK;

        if (accept)
        begin
            case (sfrr_pkg::opcode_t'(it.opcode))
                sfrr_pkg::OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push = 1'b1;
                        if (it.request_length == 16'h0000)
                        begin
                            job.op     = sfrr_pkg::JOB_DONE;
                            job.size   = start_marker;
                            job.status = sfrr_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            job.op        = sfrr_pkg::JOB_START;
                            job.size      = it.request_length;
                            discard_add   = 3'd5;
                            cap_zero_next = (it.response_capacity == 16'h0000);
                            req_rem_next  = it.request_length;
                            cap_next      = it.response_capacity;
                            deliver_next  = it.buffer_present;
                            phase_next    = PH_PAYLOAD;
                        end
                    end
                end
                sfrr_pkg::OP_PAYLOAD:
                begin
                    if (phase_reg == PH_PAYLOAD && req_rem_reg != 16'h0000)
                    begin
                        push         = 1'b1;
                        job.op       = sfrr_pkg::JOB_LINK;
                        job.data     = it.payload_byte;
                        job.hold     = (req_rem_reg != 16'd1);
                        discard_add  = 3'd1;
                        req_rem_next = req_rem_reg - 16'd1;
                        if (req_rem_reg == 16'd1)
                        begin
                            phase_next = PH_WAIT_IRQ;
                        end
                    end
                end
                sfrr_pkg::OP_IRQ:
                begin
                    if (phase_reg == PH_WAIT_IRQ)
                    begin
                        push        = 1'b1;
                        job.op      = sfrr_pkg::JOB_IRQ;
                        discard_add = 3'd2;
                        phase_next  = PH_SIZE_HI;
                    end
                end
                sfrr_pkg::OP_REPLY:
                begin
                    if (discard_reg != 17'd0)
                    begin
                        discard_next = discard_reg - 17'd1;
                    end
                    else if (phase_reg == PH_SIZE_HI)
                    begin
                        size_hi_next = it.link_reply;
                        phase_next   = PH_SIZE_LO;
                    end
                    else if (phase_reg == PH_SIZE_LO)
                    begin
                        push = 1'b1;
                        if (size_word > cap_reg)
                        begin
                            job.op     = sfrr_pkg::JOB_DONE;
                            job.size   = marker;
                            job.status = sfrr_pkg::STATUS_LARGE;
                            phase_next = PH_IDLE;
                        end
                        else if (size_word == 16'h0000)
                        begin
                            job.op     = sfrr_pkg::JOB_DONE;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            job.op        = sfrr_pkg::JOB_LINK;
                            job.data      = sfrr_pkg::FILL_BYTE;
                            job.hold      = (size_word != 16'd1);
                            cap_next      = size_word;
                            resp_rem_next = size_word;
                            phase_next    = PH_RESP;
                        end
                    end
                    else if (phase_reg == PH_RESP && resp_rem_reg != 16'h0000)
                    begin
                        push           = 1'b1;
                        job.op         = sfrr_pkg::JOB_RESP;
                        job.data       = it.link_reply;
                        job.host       = deliver_reg;
                        job.final_beat = (resp_left == 16'h0000);
                        job.hold       = (resp_left != 16'd1);
                        job.size       = cap_reg;
                        resp_rem_next  = resp_left;
                        if (resp_left == 16'h0000)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase

            // Saturate the count of link replies still to drop.
            if (discard_add != 3'd0)
            begin
                discard_next = (discard_sum > {1'b0, sfrr_pkg::DISCARD_MAX})
                             ? sfrr_pkg::DISCARD_MAX : discard_sum[16:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            req_rem_reg  <= '0;
            cap_reg      <= '0;
            resp_rem_reg <= '0;
            size_hi_reg  <= '0;
            discard_reg  <= '0;
            deliver_reg  <= 1'b0;
            cap_zero_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            req_rem_reg  <= req_rem_next;
            cap_reg      <= cap_next;
            resp_rem_reg <= resp_rem_next;
            size_hi_reg  <= size_hi_next;
            discard_reg  <= discard_next;
            deliver_reg  <= deliver_next;
            cap_zero_reg <= cap_zero_next;
        end
    end

endmodule

FILE: src/sfrr_queue.sv
// Short job queue between the front end and the beat generator.
module sfrr_queue #(
    parameter int DEPTH = sfrr_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfrr_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output sfrr_pkg::job_t head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfrr_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/sfrr_back.sv
// Back end: expands queued jobs into result beats through an output register.
module sfrr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  sfrr_pkg::job_t head_job,
    output logic           pop,
    sfrr_rsp_if.source     result
);

    logic [2:0]          beat_reg;
    logic                out_valid_reg;
    sfrr_pkg::sfrr_out_t out_reg;
    sfrr_pkg::sfrr_out_t beat;
    logic                beat_last;
    logic                load;

    assign load         = head_valid && (!out_valid_reg || result.ready);
    assign pop          = load && beat_last;
    assign result.valid = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        beat           = '0;
        beat.kind      = sfrr_pkg::KIND_LINK;
        beat.status    = sfrr_pkg::STATUS_OK;
        beat_last      = 1'b1;
        case (head_job.op)
            sfrr_pkg::JOB_DONE:
            begin
                beat.kind          = sfrr_pkg::KIND_DONE;
                beat.response_size = head_job.size;
                beat.status        = head_job.status;
            end
            sfrr_pkg::JOB_LINK:
            begin
                beat.link_byte   = head_job.data;
                beat.hold_select = head_job.hold;
            end
            sfrr_pkg::JOB_START:
            begin
                beat_last        = (beat_reg == 3'd4);
                beat.hold_select = (beat_reg != 3'd0);
                case (beat_reg)
                    3'd0:    beat.link_byte = sfrr_pkg::WAKE_BYTE;
                    3'd1:    beat.link_byte = sfrr_pkg::CMD_WRITE;
                    3'd2:    beat.link_byte = sfrr_pkg::FILL_BYTE;
                    3'd3:    beat.link_byte = head_job.size[15:8];
                    default: beat.link_byte = head_job.size[7:0];
                endcase
            end
            sfrr_pkg::JOB_IRQ:
            begin
                beat_last        = (beat_reg == 3'd3);
                beat.hold_select = 1'b1;
                beat.link_byte   = (beat_reg == 3'd0) ? sfrr_pkg::CMD_READ
                                                      : sfrr_pkg::FILL_BYTE;
            end
            sfrr_pkg::JOB_RESP:
            begin
                if (head_job.host && beat_reg == 3'd0)
                begin
                    // Hand the byte over first, then the follow-up beat.
                    beat.kind      = sfrr_pkg::KIND_HOST;
                    beat.host_byte = head_job.data;
                    beat_last      = 1'b0;
                end
                else if (head_job.final_beat)
                begin
                    beat.kind          = sfrr_pkg::KIND_DONE;
                    beat.response_size = head_job.size;
                end
                else
                begin
                    beat.link_byte   = sfrr_pkg::FILL_BYTE;
                    beat.hold_select = head_job.hold;
                end
            end
            default:
            begin
                beat_last = 1'b1;
            end
        endcase
        beat.last = beat_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            beat_reg      <= beat_last ? 3'd0 : beat_reg + 3'd1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= beat;
        end
    end

endmodule

FILE: src/spi_framed_request_response_core.sv
// Top level of the framed SPI request/response sequencer.
// Accepts one request item per cycle while the job queue has room.
// The first beat is valid once its job has passed the queue, then the output register;
// beats follow one per cycle while result is ready: a start job makes five, an interrupt four.
// Reset (rst_n low, asynchronous) idles the phase, clears counters and empties the queue.
module spi_framed_request_response_core #(
    parameter int QUEUE_DEPTH = sfrr_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sfrr_req_if.sink   request,
    sfrr_rsp_if.source result
);

    logic           push;
    logic           q_full;
    logic           pop;
    logic           head_valid;
    sfrr_pkg::job_t push_job;
    sfrr_pkg::job_t head_job;

    sfrr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .q_full  (q_full),
        .push    (push),
        .job     (push_job)
    );

    sfrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sfrr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );

endmodule
